// ===== rtl/bmf_pkg.sv =====
// Shared types and constants of the box mean filter.
`default_nettype none
package bmf_pkg;

    localparam int DEF_MAX_SIDE   = 7;
    localparam int DEF_MAX_COLS   = 4096;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int POS_W       = 12;
    localparam int DIM_W       = 14;
    localparam int HALF_W      = 2;
    localparam int QUEUE_DEPTH = 8;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Frame geometry and mode after clamping to the legal ranges
    typedef struct packed {
        logic [DIM_W-1:0]  cols;
        logic [DIM_W-1:0]  rows;
        logic [HALF_W-1:0] half;
        logic              mask_zero;
    } t_bmf_cfg;

    // Position of a window centre and the end-of-frame flag
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_bmf_pos;

endpackage
`default_nettype wire

// ===== rtl/bmf_queue.sv =====
// Short FIFO between the window front end and the divider back end.
`default_nettype none
module bmf_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    input  wire               i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_entry [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    assign o_data  = r_entry[r_rd];
    assign o_empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bmf_front.sv =====
// Front end: pixel transfer, position tracking, line stores and running window sums.
`default_nettype none
module bmf_front #(
    parameter int MAX_SIDE    = bmf_pkg::DEF_MAX_SIDE,
    parameter int MAX_COLS    = bmf_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS  = bmf_pkg::DEF_PIXEL_BITS,
    parameter int QUEUE_DEPTH = bmf_pkg::QUEUE_DEPTH
) (
    input  wire                                                    i_clk,
    input  wire                                                    i_rst_n,
    input  wire  bmf_pkg::t_bmf_cfg                                i_cfg,
    input  wire                                                    i_in_valid,
    output logic                                                   o_in_stall,
    input  wire  [PIXEL_BITS-1:0]                                  i_pixel,
    input  wire                                                    i_frame_start,
    input  wire                                                    i_pop,
    output logic                                                   o_push,
    output logic [PIXEL_BITS+$clog2(MAX_SIDE*MAX_SIDE)-1:0]         o_push_wsum,
    output bmf_pkg::t_bmf_pos                                      o_push_pos
);
    import bmf_pkg::*;

    localparam int LINES  = MAX_SIDE - 1;
    localparam int SLOT_W = $clog2(LINES);
    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int CSUM_W = PIXEL_BITS + $clog2(MAX_SIDE);
    localparam int WSUM_W = PIXEL_BITS + $clog2(MAX_SIDE * MAX_SIDE);
    localparam int SPLIT  = (MAX_SIDE + 1) / 2;
    localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);
    localparam int HMAX   = (MAX_SIDE - 1) / 2;
    localparam int NPART  = HMAX + 1;

    // Position of the next pixel
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;
    logic [POS_W-1:0]  n_row;
    logic [POS_W-1:0]  n_col;
    logic [SLOT_W-1:0] n_slot;
    logic [PEND_W-1:0] r_pending;

    logic [POS_W-1:0]    w_row0;
    logic [POS_W-1:0]    w_col0;
    logic [SLOT_W-1:0]   w_slot0;
    logic [POS_W-1:0]    w_row;
    logic [POS_W-1:0]    w_col;
    logic [SLOT_W-1:0]   w_slot;
    logic [DIM_W-1:0]    w_row_inc;
    logic [DIM_W-1:0]    w_col_inc;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [ADDR_W-1:0]   w_addr;
    logic [HALF_W:0]     w_span;
    logic [HALF_W:0]     w_side;
    logic                w_emit;
    t_bmf_pos            w_pos;
    logic                w_accept;

    // Stage registers
    logic                  r_p1_valid;
    logic [PIXEL_BITS-1:0] r_p1_pix;
    logic [SLOT_W-1:0]     r_p1_slot;
    logic                  r_p1_emit;
    t_bmf_pos              r_p1_pos;

    logic                  r_p2_valid;
    logic [CSUM_W-1:0]     r_p2_part [NPART];
    logic                  r_p2_emit;
    t_bmf_pos              r_p2_pos;

    logic                  r_p3_valid;
    logic                  r_p3_emit;
    t_bmf_pos              r_p3_pos;
    logic [CSUM_W-1:0]     r_csum [MAX_SIDE][NPART];

    logic                  r_p4_valid;
    logic [WSUM_W-1:0]     r_p4_lo;
    logic [WSUM_W-1:0]     r_p4_hi;
    logic                  r_p4_emit;
    t_bmf_pos              r_p4_pos;

    logic [PIXEL_BITS-1:0] w_line_q [LINES];
    logic [PIXEL_BITS-1:0] w_rowval [MAX_SIDE];
    logic [CSUM_W-1:0]     w_part [NPART];
    logic [CSUM_W-1:0]     w_pref [NPART];
    logic [CSUM_W-1:0]     w_csel [MAX_SIDE];
    logic [WSUM_W-1:0]     w_win_lo;
    logic [WSUM_W-1:0]     w_win_hi;

    assign o_in_stall = (r_pending == PEND_W'(QUEUE_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_span     = {i_cfg.half, 1'b0};
    assign w_side     = {i_cfg.half, 1'b1};

    // Position of this pixel and of the next one
    always_comb begin
        w_row0  = i_frame_start ? '0 : r_row;
        w_col0  = i_frame_start ? '0 : r_col;
        w_slot0 = i_frame_start ? '0 : r_slot;
        w_row   = (DIM_W'(w_row0) >= i_cfg.rows) ? '0 : w_row0;
        w_slot  = (DIM_W'(w_row0) >= i_cfg.rows) ? '0 : w_slot0;
        w_col   = (DIM_W'(w_col0) >= i_cfg.cols) ? '0 : w_col0;

        w_row_inc = DIM_W'(w_row) + DIM_W'(1);
        w_col_inc = DIM_W'(w_col) + DIM_W'(1);
        n_row     = w_row;
        n_slot    = w_slot;
        n_col     = w_col_inc[POS_W-1:0];
        if (w_col_inc >= i_cfg.cols) begin
            n_col = '0;
            if (w_row_inc >= i_cfg.rows) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = w_row_inc[POS_W-1:0];
                n_slot = (w_slot == SLOT_W'(LINES - 1)) ? '0 : w_slot + SLOT_W'(1);
            end
        end

        w_pix  = (i_cfg.mask_zero && (i_pixel == '0)) ? '1 : i_pixel;
        w_addr = ADDR_W'(w_col);
        w_emit = (w_row >= POS_W'(w_span)) && (w_col >= POS_W'(w_span));
        w_pos.row  = w_row - POS_W'(i_cfg.half);
        w_pos.col  = w_col - POS_W'(i_cfg.half);
        w_pos.last = (DIM_W'(w_row) == i_cfg.rows - DIM_W'(1)) &&
                     (DIM_W'(w_col) == i_cfg.cols - DIM_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_slot    <= '0;
            r_pending <= '0;
        end else begin
            if (w_accept) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_slot <= n_slot;
            end
            // Count results promised to the queue and not yet taken from it
            if ((w_accept && w_emit) && !i_pop) begin
                r_pending <= r_pending + PEND_W'(1);
            end else if (!(w_accept && w_emit) && i_pop) begin
                r_pending <= r_pending - PEND_W'(1);
            end
        end
    end

    // One line store per stored row; read the old entry while the new pixel goes in
    for (genvar m = 0; m < LINES; m++) begin : g_line
        logic [PIXEL_BITS-1:0] r_mem [MAX_COLS];
        logic [PIXEL_BITS-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (w_accept) begin
                if (w_slot == SLOT_W'(m)) begin
                    r_mem[w_addr] <= w_pix;
                end
                r_q <= r_mem[w_addr];
            end
        end

        assign w_line_q[m] = r_q;
    end

    // Window row k comes from the line k rows above the current one
    always_comb begin
        int idx;
        w_rowval[0] = r_p1_pix;
        for (int k = 1; k < MAX_SIDE; k++) begin
            idx = int'(r_p1_slot) + LINES - k;
            if (idx >= LINES) begin
                idx = idx - LINES;
            end
            w_rowval[k] = w_line_q[SLOT_W'(idx)];
        end
        // Pair up the rows that each larger window adds
        w_part[0] = CSUM_W'(w_rowval[0]);
        for (int g = 1; g < NPART; g++) begin
            w_part[g] = CSUM_W'(w_rowval[2*g-1]) + CSUM_W'(w_rowval[2*g]);
        end
    end

    // Column sums for every window side, so a new half width applies at once
    always_comb begin
        w_pref[0] = r_p2_part[0];
        for (int g = 1; g < NPART; g++) begin
            w_pref[g] = w_pref[g-1] + r_p2_part[g];
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_SIDE; j++) begin
            w_csel[j] = r_csum[j][0];
            for (int g = 1; g < NPART; g++) begin
                if (int'(i_cfg.half) == g) begin
                    w_csel[j] = r_csum[j][g];
                end
            end
        end
        w_win_lo = '0;
        w_win_hi = '0;
        for (int j = 0; j < MAX_SIDE; j++) begin
            if (j < int'(w_side)) begin
                if (j < SPLIT) begin
                    w_win_lo = w_win_lo + WSUM_W'(w_csel[j]);
                end else begin
                    w_win_hi = w_win_hi + WSUM_W'(w_csel[j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else begin
            r_p1_valid <= w_accept;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_pix  <= w_pix;
        r_p1_slot <= w_slot;
        r_p1_emit <= w_emit;
        r_p1_pos  <= w_pos;

        for (int g = 0; g < NPART; g++) begin
            r_p2_part[g] <= w_part[g];
        end
        r_p2_emit <= r_p1_emit;
        r_p2_pos  <= r_p1_pos;

        // Advance the column sums by one column per pixel
        if (r_p2_valid) begin
            for (int g = 0; g < NPART; g++) begin
                r_csum[0][g] <= w_pref[g];
            end
            for (int j = 1; j < MAX_SIDE; j++) begin
                for (int g = 0; g < NPART; g++) begin
                    r_csum[j][g] <= r_csum[j-1][g];
                end
            end
        end
        r_p3_emit <= r_p2_emit;
        r_p3_pos  <= r_p2_pos;

        r_p4_lo   <= w_win_lo;
        r_p4_hi   <= w_win_hi;
        r_p4_emit <= r_p3_emit;
        r_p4_pos  <= r_p3_pos;
    end

    assign o_push      = r_p4_valid && r_p4_emit;
    assign o_push_wsum = r_p4_lo + r_p4_hi;
    assign o_push_pos  = r_p4_pos;

endmodule
`default_nettype wire

// ===== rtl/bmf_back.sv =====
// Back end: division of the window sum by the window area and the output register.
`default_nettype none
module bmf_back #(
    parameter int MAX_SIDE   = bmf_pkg::DEF_MAX_SIDE,
    parameter int PIXEL_BITS = bmf_pkg::DEF_PIXEL_BITS
) (
    input  wire                                               i_clk,
    input  wire                                               i_rst_n,
    input  wire  [bmf_pkg::HALF_W-1:0]                        i_half,
    input  wire                                               i_item_valid,
    input  wire  [PIXEL_BITS+$clog2(MAX_SIDE*MAX_SIDE)-1:0]    i_wsum,
    input  wire  bmf_pkg::t_bmf_pos                           i_pos,
    output logic                                              o_pop,
    output logic                                              o_out_valid,
    input  wire                                               i_out_stall,
    output logic [PIXEL_BITS-1:0]                             o_mean_value,
    output logic [bmf_pkg::POS_W-1:0]                         o_center_row,
    output logic [bmf_pkg::POS_W-1:0]                         o_center_col,
    output logic                                              o_frame_last
);
    import bmf_pkg::*;

    localparam int WSUM_W  = PIXEL_BITS + $clog2(MAX_SIDE * MAX_SIDE);
    localparam int RSH     = WSUM_W;
    localparam int RECIP_W = RSH + 1;
    localparam int PROD_W  = WSUM_W + RECIP_W;
    localparam int SQ_W    = 6;
    localparam int NUM_H   = 4;
    localparam longint ONE = longint'(1) << RSH;

    // Window areas for half widths 0..3 and their scaled reciprocals
    localparam logic [SQ_W-1:0] AREA [NUM_H] = '{6'd1, 6'd9, 6'd25, 6'd49};
    localparam logic [RECIP_W-1:0] RECIP [NUM_H] = '{
        RECIP_W'(ONE / 1), RECIP_W'(ONE / 9), RECIP_W'(ONE / 25), RECIP_W'(ONE / 49)
    };

    logic                    w_adv;
    logic                    r_b1_valid;
    logic [PROD_W-1:0]       r_b1_prod;
    logic [WSUM_W-1:0]       r_b1_x;
    logic [HALF_W-1:0]       r_b1_half;
    t_bmf_pos                r_b1_pos;

    logic [PIXEL_BITS-1:0]   w_q0;
    logic [PIXEL_BITS+SQ_W-1:0] w_qd;

    logic                    r_b2_valid;
    logic [PIXEL_BITS-1:0]   r_b2_q0;
    logic [WSUM_W-1:0]       r_b2_rem;
    logic [HALF_W-1:0]       r_b2_half;
    t_bmf_pos                r_b2_pos;

    logic                    r_out_valid;
    logic [PIXEL_BITS-1:0]   r_mean;
    t_bmf_pos                r_out_pos;

    // The whole back end moves together whenever the output register can take
    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_pop = w_adv && i_item_valid;

    assign w_q0 = r_b1_prod[RSH +: PIXEL_BITS];
    assign w_qd = w_q0 * AREA[r_b1_half];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_b1_valid  <= i_item_valid;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // Quotient estimate, low by at most one
            r_b1_prod <= i_wsum * RECIP[i_half];
            r_b1_x    <= i_wsum;
            r_b1_half <= i_half;
            r_b1_pos  <= i_pos;

            r_b2_q0   <= w_q0;
            r_b2_rem  <= r_b1_x - WSUM_W'(w_qd);
            r_b2_half <= r_b1_half;
            r_b2_pos  <= r_b1_pos;

            // Correct the estimate where the remainder still holds one area
            r_mean    <= (r_b2_rem >= WSUM_W'(AREA[r_b2_half])) ?
                         r_b2_q0 + PIXEL_BITS'(1) : r_b2_q0;
            r_out_pos <= r_b2_pos;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mean_value = r_mean;
    assign o_center_row = r_out_pos.row;
    assign o_center_col = r_out_pos.col;
    assign o_frame_last = r_out_pos.last;

endmodule
`default_nettype wire

// ===== rtl/box_mean_filter_2d.sv =====
// Top level of the streaming 2-D box mean filter with its register port.
//
// Takes one pixel per transfer in raster order and returns the truncated mean of the
// square window of side 2*half_side+1 for each position where the window lies wholly
// inside the frame, with the row and column of the window centre; border positions give
// no result. A zero pixel reads as all ones when zero_is_mask is set. The block accepts
// one pixel per clock while results are taken; a result passes through four front stages
// (line store read, column partial sums, column shift, window sum), the queue and three
// back stages for the reciprocal multiply and its correction. Pixel input stalls only
// when the eight-entry result queue is spoken for by results in flight. The line stores
// are MAX_SIDE-1 single-port-write memories of MAX_COLS entries and need no clearing
// after reset. Registers may be written only while no pixel or result is in flight, and
// frame_cols only between frames.
`default_nettype none
module box_mean_filter_2d #(
    parameter int MAX_SIDE   = bmf_pkg::DEF_MAX_SIDE,
    parameter int MAX_COLS   = bmf_pkg::DEF_MAX_COLS,
    parameter int PIXEL_BITS = bmf_pkg::DEF_PIXEL_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [bmf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire  [bmf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bmf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  [PIXEL_BITS-1:0]              i_pixel,
    input  wire                                i_frame_start,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [PIXEL_BITS-1:0]              o_mean_value,
    output logic [bmf_pkg::POS_W-1:0]          o_center_row,
    output logic [bmf_pkg::POS_W-1:0]          o_center_col,
    output logic                               o_frame_last
);
    import bmf_pkg::*;

    localparam int FRAME_DIM_W = 13;
    localparam int MIN_DIM     = 3;
    localparam int MAX_ROWS    = 4096;
    localparam int HMAX        = (MAX_SIDE - 1) / 2;
    localparam int REG_LSB     = 2;
    localparam int REG_W       = CFG_ADDR_W - REG_LSB;
    localparam int WSUM_W      = PIXEL_BITS + $clog2(MAX_SIDE * MAX_SIDE);
    localparam int POS_BITS    = $bits(t_bmf_pos);
    localparam int ENTRY_W     = WSUM_W + POS_BITS;

    localparam logic [REG_W-1:0] REG_FRAME_COLS   = 2'd0;
    localparam logic [REG_W-1:0] REG_FRAME_ROWS   = 2'd1;
    localparam logic [REG_W-1:0] REG_HALF_SIDE    = 2'd2;
    localparam logic [REG_W-1:0] REG_ZERO_IS_MASK = 2'd3;

    logic [FRAME_DIM_W-1:0] r_frame_cols;
    logic [FRAME_DIM_W-1:0] r_frame_rows;
    logic [HALF_W-1:0]      r_half_side;
    logic                   r_zero_is_mask;

    logic                   w_cfg_wr;
    logic [REG_W-1:0]       w_reg_idx;
    t_bmf_cfg               w_cfg;

    logic                   w_push;
    logic [WSUM_W-1:0]      w_push_wsum;
    t_bmf_pos               w_push_pos;
    logic                   w_pop;
    logic [ENTRY_W-1:0]     w_q_data;
    logic                   w_q_empty;
    logic [WSUM_W-1:0]      w_q_wsum;
    t_bmf_pos               w_q_pos;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[CFG_ADDR_W-1:REG_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols   <= FRAME_DIM_W'(4096);
            r_frame_rows   <= FRAME_DIM_W'(4096);
            r_half_side    <= HALF_W'(2);
            r_zero_is_mask <= 1'b1;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_FRAME_COLS:   r_frame_cols   <= pwdata[FRAME_DIM_W-1:0];
                REG_FRAME_ROWS:   r_frame_rows   <= pwdata[FRAME_DIM_W-1:0];
                REG_HALF_SIDE:    r_half_side    <= pwdata[HALF_W-1:0];
                REG_ZERO_IS_MASK: r_zero_is_mask <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_FRAME_COLS:   prdata = CFG_DATA_W'(r_frame_cols);
            REG_FRAME_ROWS:   prdata = CFG_DATA_W'(r_frame_rows);
            REG_HALF_SIDE:    prdata = CFG_DATA_W'(r_half_side);
            REG_ZERO_IS_MASK: prdata = CFG_DATA_W'(r_zero_is_mask);
        endcase
    end

    // Clamp the geometry to what the line stores and window can hold
    always_comb begin
        if (r_frame_cols < FRAME_DIM_W'(MIN_DIM)) begin
            w_cfg.cols = DIM_W'(MIN_DIM);
        end else if (DIM_W'(r_frame_cols) > DIM_W'(MAX_COLS)) begin
            w_cfg.cols = DIM_W'(MAX_COLS);
        end else begin
            w_cfg.cols = DIM_W'(r_frame_cols);
        end
        if (r_frame_rows < FRAME_DIM_W'(MIN_DIM)) begin
            w_cfg.rows = DIM_W'(MIN_DIM);
        end else if (DIM_W'(r_frame_rows) > DIM_W'(MAX_ROWS)) begin
            w_cfg.rows = DIM_W'(MAX_ROWS);
        end else begin
            w_cfg.rows = DIM_W'(r_frame_rows);
        end
        w_cfg.half      = (int'(r_half_side) > HMAX) ? HALF_W'(HMAX) : r_half_side;
        w_cfg.mask_zero = r_zero_is_mask;
    end

    bmf_front #(
        .MAX_SIDE    (MAX_SIDE),
        .MAX_COLS    (MAX_COLS),
        .PIXEL_BITS  (PIXEL_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_pop         (w_pop),
        .o_push        (w_push),
        .o_push_wsum   (w_push_wsum),
        .o_push_pos    (w_push_pos)
    );

    bmf_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_wsum, w_push_pos}),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    assign w_q_wsum = w_q_data[ENTRY_W-1 -: WSUM_W];
    assign w_q_pos  = w_q_data[POS_BITS-1:0];

    bmf_back #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_half       (w_cfg.half),
        .i_item_valid (!w_q_empty),
        .i_wsum       (w_q_wsum),
        .i_pos        (w_q_pos),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mean_value (o_mean_value),
        .o_center_row (o_center_row),
        .o_center_col (o_center_col),
        .o_frame_last (o_frame_last)
    );

endmodule
`default_nettype wire
